[sv/anchor_chain_dp_assert.svh]
// Assertion macros used by the anchor chaining top level.
`ifndef ANCHOR_CHAIN_DP_ASSERT_SVH
`define ANCHOR_CHAIN_DP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ACD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/acd_pkg.sv]
// Package with types and constants of the anchor chaining block.
`timescale 1ns / 1ps
`default_nettype none
package acd_pkg;

    localparam int ACD_MAX_ANCHORS = 64;
    localparam logic [15:0] ACD_GAP_RESET = 16'd1024;

    typedef struct packed {
        logic [31:0] ref_pos;
        logic [15:0] read_pos;
        logic [15:0] anchor_len;
        logic        last_anchor;
    } t_anchor_in;

    typedef struct packed {
        logic [5:0]  anchor_index;
        logic [21:0] chain_score;
        logic        is_last;
    } t_chain_out;

    // Predecessor data driven to every cell during the scan.
    typedef struct packed {
        logic        valid;
        logic [32:0] ref_end;
        logic [16:0] read_end;
        logic [17:0] read_lim;
        logic [21:0] score;
    } t_bcast;

    // Current node data driven to every cell during the walk back.
    typedef struct packed {
        logic [21:0] score;
        logic [15:0] len;
    } t_bt;

    // What one cell shows of its anchor.
    typedef struct packed {
        logic [31:0] ref_pos;
        logic [15:0] read_pos;
        logic [15:0] anchor_len;
        logic [21:0] score;
    } t_cell_view;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_BACK
    } t_state;

endpackage
`default_nettype wire

[sv/anchor_chain_dp.sv]
// Top level of the seed anchor chaining block.
`timescale 1ns / 1ps
`default_nettype none
// Anchors load one per cycle into a row of cells; busy stays low while
// loading. The word marked last_anchor starts chaining: a clear state, then,
// with two anchors or more, the scan, which steps through each predecessor i
// (n-1 of them for n anchors held): anchor i is driven to all cells and each
// later cell tests its edge and updates its score. The walk back then steps
// from the chain's end node toward its start, and busy stays high from the
// clear state until it ends. Results come out on o_result with o_strobe high
// for one cycle each and cannot be held off; the final one carries is_last.
// Anchors past MAX_ANCHORS are dropped. Configuration is always ready.
module anchor_chain_dp
    import acd_pkg::*;
#(
    parameter int MAX_ANCHORS = ACD_MAX_ANCHORS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_anchor_in  i_cmd,
    output logic             o_strobe,
    output t_chain_out       o_result,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    `include "anchor_chain_dp_assert.svh"

    localparam int IW = $clog2(MAX_ANCHORS);
    localparam int CW = $clog2(MAX_ANCHORS+1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_n, n_n;
    logic [IW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_end, n_end;
    logic [IW-1:0]   r_cur, n_cur;
    logic            r_pend_v, n_pend_v;
    logic [IW-1:0]   r_pend_idx, n_pend_idx;
    logic [21:0]     r_pend_score, n_pend_score;
    logic [15:0]     r_gap;
    logic            r_strobe, n_strobe;
    t_chain_out      r_result, n_result;

    t_cell_view             w_view [MAX_ANCHORS];
    logic [MAX_ANCHORS-1:0] w_pred [MAX_ANCHORS];
    logic [MAX_ANCHORS-1:0] w_edge, w_match, w_load, w_cur_pred;
    logic                   w_accept, w_clr;
    t_bcast                 w_bc;
    t_bt                    w_bt;
    logic [IW-1:0]          w_hi, w_lo;
    logic                   w_found;
    t_cell_view             w_src;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;
    assign w_clr       = (r_state == ST_CLEAR);
    assign w_found     = |w_match;

    always_comb begin
        w_src      = w_view[r_i];
        w_bc.valid = (r_state == ST_SCAN);
        w_bc.ref_end  = {1'b0, w_src.ref_pos} + {17'b0, w_src.anchor_len};
        w_bc.read_end = {1'b0, w_src.read_pos} + {1'b0, w_src.anchor_len};
        w_bc.read_lim = {1'b0, w_bc.read_end} + {2'b0, r_gap};
        w_bc.score    = w_src.score;
        w_bt.score = w_view[r_cur].score;
        w_bt.len   = w_view[r_cur].anchor_len;
        w_cur_pred = (r_state == ST_BACK) ? w_pred[r_cur] : '0;
        for (int k = 0; k < MAX_ANCHORS; k++) begin
            w_load[k] = w_accept && (r_count == CW'(k));
        end
    end

    // Highest edge target this scan step and lowest matching predecessor.
    always_comb begin
        w_hi = '0;
        w_lo = '0;
        for (int k = 0; k < MAX_ANCHORS; k++) begin
            if (w_edge[k]) w_hi = IW'(k);
        end
        for (int k = MAX_ANCHORS - 1; k >= 0; k--) begin
            if (w_match[k]) w_lo = IW'(k);
        end
    end

    for (genvar g = 0; g < MAX_ANCHORS; g++) begin : g_cell
        acd_cell #(.MAX_ANCHORS(MAX_ANCHORS), .K(g)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (w_load[g]),
            .i_in      (i_cmd),
            .i_clr     (w_clr),
            .i_bc      (w_bc),
            .i_bidx    (r_i),
            .i_count   (r_n),
            .i_bt      (w_bt),
            .i_bt_edge (w_cur_pred[g]),
            .o_view    (w_view[g]),
            .o_pred    (w_pred[g]),
            .o_edge    (w_edge[g]),
            .o_match   (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_n      <= '0;
            r_i      <= '0;
            r_end    <= '0;
            r_cur    <= '0;
            r_pend_v <= 1'b0;
            r_gap    <= ACD_GAP_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_n      <= n_n;
            r_i      <= n_i;
            r_end    <= n_end;
            r_cur    <= n_cur;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) r_gap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx   <= n_pend_idx;
        r_pend_score <= n_pend_score;
        r_result     <= n_result;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_n          = r_n;
        n_i          = r_i;
        n_end        = r_end;
        n_cur        = r_cur;
        n_pend_v     = r_pend_v;
        n_pend_idx   = r_pend_idx;
        n_pend_score = r_pend_score;
        n_strobe     = 1'b0;
        n_result     = r_result;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_count < CW'(MAX_ANCHORS)) n_count = r_count + 1'b1;
                    if (i_cmd.last_anchor) begin
                        n_n     = n_count;
                        n_count = '0;
                        n_state = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                n_i      = '0;
                n_end    = '0;
                n_cur    = '0;
                n_pend_v = 1'b0;
                n_state  = (r_n >= CW'(2)) ? ST_SCAN : ST_BACK;
            end
            ST_SCAN: begin
                if (|w_edge) n_end = w_hi;
                if (CW'(r_i) == (r_n - CW'(2))) begin
                    n_cur   = n_end;
                    n_state = ST_BACK;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_BACK: begin
                if (w_found) begin
                    // Emit the held word; its successor exists.
                    if (r_pend_v) begin
                        n_strobe = 1'b1;
                        n_result = '{anchor_index: 6'(r_pend_idx),
                                     chain_score: r_pend_score, is_last: 1'b0};
                    end
                    n_pend_v     = 1'b1;
                    n_pend_idx   = w_lo;
                    n_pend_score = w_view[w_lo].score;
                    n_cur        = w_lo;
                end else begin
                    if (r_pend_v) begin
                        n_strobe = 1'b1;
                        n_result = '{anchor_index: 6'(r_pend_idx),
                                     chain_score: r_pend_score, is_last: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `ACD_ASSERT_NOW(a_strobe_from_walk, r_strobe, $past(r_state == ST_BACK), "strobe outside walk")
    `ACD_ASSERT_NEXT(a_walk_ends, (r_state == ST_BACK) && !w_found, r_state == ST_IDLE, "walk did not end")
    `ACD_ASSERT_NEXT(a_walk_descends, (r_state == ST_BACK) && w_found, r_cur < $past(r_cur), "walk not descending")
    `ACD_ASSERT_NEXT(a_last_single, r_strobe && r_result.is_last, !r_strobe && !r_pend_v, "word after last")

endmodule
`default_nettype wire

[sv/acd_cell.sv]
// One chaining cell: holds an anchor, its score and its predecessor mask.
`timescale 1ns / 1ps
`default_nettype none
module acd_cell
    import acd_pkg::*;
#(
    parameter int MAX_ANCHORS = ACD_MAX_ANCHORS,
    parameter int K = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_load,
    input  wire t_anchor_in                         i_in,
    input  wire logic                               i_clr,
    input  wire t_bcast                             i_bc,
    input  wire logic [$clog2(MAX_ANCHORS)-1:0]     i_bidx,
    input  wire logic [$clog2(MAX_ANCHORS+1)-1:0]   i_count,
    input  wire t_bt                                i_bt,
    input  wire logic                               i_bt_edge,
    output t_cell_view                              o_view,
    output logic [MAX_ANCHORS-1:0]                  o_pred,
    output logic                                    o_edge,
    output logic                                    o_match
);
    localparam int IW = $clog2(MAX_ANCHORS);
    localparam int CW = $clog2(MAX_ANCHORS+1);

    logic [31:0]            r_ref;
    logic [15:0]            r_read;
    logic [15:0]            r_len;
    logic [21:0]            r_score;
    logic [MAX_ANCHORS-1:0] r_pred;
    logic [21:0]            w_cand;

    always_comb begin
        o_edge = i_bc.valid && (IW'(K) > i_bidx) && (CW'(K) < i_count)
              && ({1'b0, r_ref} >= i_bc.ref_end)
              && ({1'b0, r_read} >= i_bc.read_end)
              && ({2'b0, r_read} <= i_bc.read_lim);
        w_cand  = i_bc.score + 22'(r_len);
        o_match = i_bt_edge && ({1'b0, i_bt.score} == ({7'b0, i_bt.len} + {1'b0, r_score}));
        o_view  = '{ref_pos: r_ref, read_pos: r_read, anchor_len: r_len, score: r_score};
        o_pred  = r_pred;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ref  <= i_in.ref_pos;
            r_read <= i_in.read_pos;
            r_len  <= i_in.anchor_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score <= '0;
            r_pred  <= '0;
        end else if (i_clr) begin
            r_score <= '0;
            r_pred  <= '0;
        end else if (o_edge) begin
            r_pred[i_bidx] <= 1'b1;
            if (w_cand > r_score) r_score <= w_cand;
        end
    end
endmodule
`default_nettype wire

[tb/sv/tb_anchor_chain_dp.sv]
// Self-checking testbench for the anchor chaining block.
`timescale 1ns / 1ps
`default_nettype none

class chain_scoreboard;
    logic [31:0] ref_st[64];
    logic [15:0] read_st[64];
    logic [15:0] len_st[64];
    logic [63:0] edges[64];
    logic [21:0] score[64];
    int unsigned held;
    logic [15:0] gap_limit;
    acd_pkg::t_chain_out pending[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned chains;

    function void reset_state();
        held = 0;
        gap_limit = acd_pkg::ACD_GAP_RESET;
        mismatches = 0;
        checked = 0;
        chains = 0;
    endfunction

    // Build edges and scores over the held set; return the end node.
    function int unsigned build_chain(int unsigned n);
        int unsigned end_node;
        logic [32:0] ref_end;
        logic [16:0] read_end;
        logic [21:0] cand;
        end_node = 0;
        for (int unsigned i = 0; i < n; i++) begin
            edges[i] = '0;
            score[i] = '0;
        end
        for (int unsigned i = 0; i + 1 < n; i++) begin
            ref_end = {1'b0, ref_st[i]} + len_st[i];
            read_end = {1'b0, read_st[i]} + len_st[i];
            for (int unsigned j = i + 1; j < n; j++) begin
                if ({1'b0, ref_st[j]} >= ref_end && {1'b0, read_st[j]} >= read_end &&
                    {2'b0, read_st[j]} <= {1'b0, read_end} + gap_limit) begin
                    cand = score[i] + len_st[j];
                    edges[i][j] = 1'b1;
                    if (cand > score[j]) score[j] = cand;
                    end_node = j;
                end
            end
        end
        return end_node;
    endfunction

    function void note_anchor(acd_pkg::t_anchor_in w);
        int unsigned cur, nxt, emitted, n;
        acd_pkg::t_chain_out r;
        if (held < 64) begin
            ref_st[held] = w.ref_pos;
            read_st[held] = w.read_pos;
            len_st[held] = w.anchor_len;
            held++;
        end
        if (!w.last_anchor) return;
        n = held;
        held = 0;
        chains++;
        cur = build_chain(n);
        emitted = 0;
        while (cur != 0 && emitted < 63) begin
            nxt = cur;
            for (int unsigned i = 0; i < cur; i++) begin
                if (edges[i][cur] && score[cur] == 22'(len_st[cur] + score[i])) begin
                    nxt = i;
                    break;
                end
            end
            if (nxt == cur) break;
            r.anchor_index = nxt[5:0];
            r.chain_score = score[nxt];
            r.is_last = 1'b0;
            pending.push_back(r);
            emitted++;
            cur = nxt;
        end
        if (emitted > 0) pending[pending.size() - 1].is_last = 1'b1;
    endfunction

    function void check_result(acd_pkg::t_chain_out got);
        acd_pkg::t_chain_out want;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        if (got.anchor_index !== want.anchor_index || got.chain_score !== want.chain_score ||
            got.is_last !== want.is_last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
    endfunction
endclass

module tb_anchor_chain_dp;
    import acd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_anchor_in  i_cmd;
    logic        o_strobe;
    t_chain_out  o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    chain_scoreboard sb;
    int unsigned idle_pct;
    int unsigned words_sent;

    anchor_chain_dp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_strobe(o_strobe), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    // Leave start high on return; the next word or a drain takes it over.
    task automatic send_anchor(input t_anchor_in w);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_anchor(w);
        words_sent++;
    endtask

    task automatic drain();
        int unsigned guard;
        start <= 1'b0;
        guard = 0;
        while ((sb.pending.size() != 0 || busy) && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_gap(input logic [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.gap_limit = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_anchor_in mk(input logic [31:0] r, input logic [15:0] p,
                                      input logic [15:0] l, input logic e);
        t_anchor_in w;
        w.ref_pos = r;
        w.read_pos = p;
        w.anchor_len = l;
        w.last_anchor = e;
        return w;
    endfunction

    // Send a mostly collinear set so chains form; some words are noise.
    task automatic send_set(input int unsigned n);
        logic [31:0] r;
        logic [15:0] p, l;
        r = $urandom_range(1000);
        p = 16'($urandom_range(200));
        for (int unsigned k = 0; k < n; k++) begin
            l = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
            if ($urandom_range(9) == 0) send_anchor(mk($urandom, 16'($urandom), l, k == n - 1));
            else send_anchor(mk(r, p, l, k == n - 1));
            r = r + l + $urandom_range(0, 30);
            p = 16'(p + l + (($urandom_range(3) == 0) ? $urandom_range(0, 2000)
                                                      : $urandom_range(0, 20)));
            if ($urandom_range(7) == 0) p = 16'(p - $urandom_range(1, 30));
        end
    endtask

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        sb = new();
        sb.reset_state();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        idle_pct = 0;
        words_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lone anchor, no edges, extremes, simple chain.
        send_anchor(mk(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_anchor(mk(32'd0, 16'd0, 16'd0, 1'b0));
        send_anchor(mk(32'd0, 16'd0, 16'd0, 1'b1));
        send_anchor(mk(32'd0, 16'd0, 16'd10, 1'b0));
        send_anchor(mk(32'd10, 16'd10, 16'd5, 1'b0));
        send_anchor(mk(32'd15, 16'd15, 16'hFFFF, 1'b0));
        send_anchor(mk(32'hFFFF_0000, 16'hFFF0, 16'h0F, 1'b1));
        send_anchor(mk(32'd5, 16'd100, 16'd3, 1'b0));
        send_anchor(mk(32'd1, 16'd1, 16'd3, 1'b1));
        write_gap(16'd0);
        send_anchor(mk(32'd0, 16'd0, 16'd4, 1'b0));
        send_anchor(mk(32'd4, 16'd4, 16'd4, 1'b0));
        send_anchor(mk(32'd8, 16'd9, 16'd4, 1'b1));
        write_gap(16'hFFFF);
        send_anchor(mk(32'd0, 16'd0, 16'd1, 1'b0));
        send_anchor(mk(32'd1, 16'hFFFE, 16'd1, 1'b1));
        drain();
        // Overflow of capacity: 70 words, the last six dropped, the final one still starts chaining.
        for (int k = 0; k < 70; k++) send_anchor(mk(32'(k * 2), 16'(k * 2), 16'd2, k == 69));

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  write_gap(16'd1024); end
                1: begin idle_pct = 88; write_gap(16'd30); end
                2: begin idle_pct = 12; write_gap(16'($urandom)); end
                default: begin idle_pct = 0; write_gap(16'd500); end
            endcase
            while (words_sent < 117 * (ph + 1)) begin
                send_set(($urandom_range(15) == 0) ? 64 : $urandom_range(2, 12));
                if ($urandom_range(9) == 0) drain();
            end
        end
        drain();
        $display("Sent %0d anchor words over %0d chaining passes; %0d results checked.",
                 words_sent, sb.chains, sb.checked);
        $display("Gap limits covered 0, 30, 500, 1024, 65535 and a random value.");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
